// File: src/pfa_pkg.sv
// Shared constants for the paged frame allocator.
// Used by the frame map, the page table memory and the top level.
package pfa_pkg;

	// sizes of the stores
	localparam int MAX_FRAMES      = 64;
	localparam int MAX_PROCESSES   = 8;
	localparam int MAX_PAGES       = 64;
	localparam int FRAME_W         = 6;
	localparam int SLOT_W          = 3;
	localparam int PAGE_W          = 6;
	localparam int PTAB_AW         = SLOT_W + PAGE_W;
	localparam int CNT_W           = 7;

	// configuration register indexes
	localparam logic CFG_PAGE_SIZE   = 1'b0;
	localparam logic CFG_FRAME_COUNT = 1'b1;

	// commands
	localparam logic [1:0] CMD_CREATE    = 2'd0;
	localparam logic [1:0] CMD_REMOVE    = 2'd1;
	localparam logic [1:0] CMD_RESIZE    = 2'd2;
	localparam logic [1:0] CMD_TRANSLATE = 2'd3;

	// status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_OOM     = 3'd1;
	localparam logic [2:0] ST_UNKNOWN = 3'd2;
	localparam logic [2:0] ST_RANGE   = 3'd3;
	localparam logic [2:0] ST_FULL    = 3'd4;

endpackage

// File: src/pfa_fmap.sv
// Frame-used map: one bit per physical frame, synchronous read.
// Depends on pfa_pkg.
module pfa_fmap (
	input  logic                       clk,
	input  logic                       we,
	input  logic [pfa_pkg::FRAME_W-1:0] waddr,
	input  logic                       wdata,
	input  logic [pfa_pkg::FRAME_W-1:0] raddr,
	output logic                       rdata
);

	logic mem_q [pfa_pkg::MAX_FRAMES];
	logic rdata_q;

	// one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: src/pfa_ptab.sv
// Page table memory: frame number per (process slot, page), synchronous read.
// Depends on pfa_pkg.
module pfa_ptab (
	input  logic                        clk,
	input  logic                        we,
	input  logic [pfa_pkg::PTAB_AW-1:0] waddr,
	input  logic [pfa_pkg::FRAME_W-1:0] wdata,
	input  logic [pfa_pkg::PTAB_AW-1:0] raddr,
	output logic [pfa_pkg::FRAME_W-1:0] rdata
);

	logic [pfa_pkg::FRAME_W-1:0] mem_q [pfa_pkg::MAX_PROCESSES * pfa_pkg::MAX_PAGES];
	logic [pfa_pkg::FRAME_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: src/paged_frame_allocator.sv
// Paged frame allocator: one request at a time, one result per request. After
// reset a clearing pass marks every frame free, with in_stall high. Every
// request starts with a pass over the frame map memory that counts the free
// frames (the page-size divider runs alongside). Create and remove then finish
// through S_DISPATCH and S_DONE, translate through S_DISPATCH, S_TR_WAIT and
// S_DONE. A growing resize scans the frame map once more, one frame a cycle; a
// shrinking resize passes through S_SH_RD and S_SH_WR for each freed page,
// through the page table memory. A stalled result holds the block in its last
// state. The page table is not cleared at reset.
// Depends on pfa_pkg, pfa_fmap and pfa_ptab.
module paged_frame_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [31:0] pid,
	input  logic [18:0] size_bytes,
	input  logic [5:0]  page_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [5:0]  frame,
	output logic [6:0]  free_frames,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [12:0] cfg_wdata
);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_COUNT, S_DISPATCH, S_GROW, S_SH_RD, S_SH_WR, S_TR_WAIT,
		S_DONE
	} state_t;

	localparam int FW = pfa_pkg::FRAME_W;
	localparam int SW = pfa_pkg::SLOT_W;
	localparam int CW = pfa_pkg::CNT_W;
	localparam logic [CW-1:0] NFRAMES = CW'(pfa_pkg::MAX_FRAMES);

	state_t state_q;

	// configuration
	logic [12:0]   page_size_q;
	logic [CW-1:0] frame_count_q;

	// request
	logic [1:0]  cmd_q;
	logic [31:0] pid_q;
	logic [5:0]  page_q;

	// divider
	logic [18:0] div_d_q;
	logic [18:0] quo_q;
	logic [12:0] rem_q;
	logic [4:0]  div_cnt_q;

	// scan and work registers
	logic [CW-1:0] scan_q;
	logic          rd_v_s1;
	logic [FW-1:0] rd_addr_s1;
	logic [CW-1:0] free_q;
	logic [SW-1:0] slot_q;
	logic [CW-1:0] have_q;
	logic [CW-1:0] want_q;
	logic [2:0]    res_status_q;
	logic [FW-1:0] res_frame_q;

	// process table
	logic          pvalid_q [pfa_pkg::MAX_PROCESSES];
	logic [31:0]   pid_tab_q [pfa_pkg::MAX_PROCESSES];
	logic [CW-1:0] pcnt_q [pfa_pkg::MAX_PROCESSES];

	// outputs
	logic          out_valid_q;
	logic [2:0]    status_q;
	logic [FW-1:0] frame_q;
	logic [CW-1:0] free_out_q;

	// memory ports
	logic                        fm_we, fm_wdata, fm_rdata;
	logic [FW-1:0]               fm_waddr, fm_raddr;
	logic                        pt_we;
	logic [pfa_pkg::PTAB_AW-1:0] pt_waddr, pt_raddr;
	logic [FW-1:0]               pt_wdata, pt_rdata;

	pfa_fmap u_fmap (
		.clk   (clk),
		.we    (fm_we),
		.waddr (fm_waddr),
		.wdata (fm_wdata),
		.raddr (fm_raddr),
		.rdata (fm_rdata)
	);

	pfa_ptab u_ptab (
		.clk   (clk),
		.we    (pt_we),
		.waddr (pt_waddr),
		.wdata (pt_wdata),
		.raddr (pt_raddr),
		.rdata (pt_rdata)
	);

	// active frame limit and effective page size
	logic [CW-1:0] frames_act;
	logic [12:0]   ps_eff;
	assign frames_act = (frame_count_q > NFRAMES) ? NFRAMES : frame_count_q;
	assign ps_eff     = (page_size_q == 13'd0) ? 13'd1 : page_size_q;

	// process lookup: lowest matching valid slot, lowest free slot
	logic          hit, has_free;
	logic [SW-1:0] hit_slot, free_slot;
	always_comb begin
		hit       = 1'b0;
		hit_slot  = '0;
		has_free  = 1'b0;
		free_slot = '0;
		for (int s = pfa_pkg::MAX_PROCESSES - 1; s >= 0; s--) begin
			if (pvalid_q[s] && pid_tab_q[s] == pid_q) begin
				hit      = 1'b1;
				hit_slot = SW'(s);
			end
			if (!pvalid_q[s]) begin
				has_free  = 1'b1;
				free_slot = SW'(s);
			end
		end
	end

	// page count of the request
	logic          rnz, too_big;
	logic [CW-1:0] want_c, have_c;
	assign rnz     = (rem_q != 13'd0);
	assign too_big = (quo_q > 19'd64) || (quo_q == 19'd64 && rnz);
	assign want_c  = quo_q[CW-1:0] + CW'(rnz);
	assign have_c  = pcnt_q[hit_slot];

	// divider step
	logic [13:0] rsh;
	logic        ge;
	assign rsh = {rem_q, div_d_q[18]};
	assign ge  = (rsh >= {1'b0, ps_eff});

	// scan response useful for the active frames
	logic resp_free;
	assign resp_free = rd_v_s1 && !fm_rdata && ({1'b0, rd_addr_s1} < frames_act);

	// memory addressing
	always_comb begin
		fm_raddr = scan_q[FW-1:0];
		fm_we    = 1'b0;
		fm_waddr = rd_addr_s1;
		fm_wdata = 1'b1;
		pt_we    = 1'b0;
		pt_waddr = {slot_q, have_q[FW-1:0]};
		pt_wdata = rd_addr_s1;
		pt_raddr = {hit_slot, page_q};
		case (state_q)
			S_CLEAR: begin
				fm_we    = 1'b1;
				fm_waddr = scan_q[FW-1:0];
				fm_wdata = 1'b0;
			end
			S_GROW: begin
				if (resp_free && have_q != want_q) begin
					fm_we = 1'b1;
					pt_we = 1'b1;
				end
			end
			S_SH_RD: begin
				pt_raddr = {slot_q, FW'(have_q - CW'(1))};
			end
			S_SH_WR: begin
				fm_we    = 1'b1;
				fm_waddr = pt_rdata;
				fm_wdata = 1'b0;
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			page_size_q   <= 13'd32;
			frame_count_q <= 7'd64;
			out_valid_q   <= 1'b0;
			div_cnt_q     <= 5'd19;
			scan_q        <= '0;
			rd_v_s1       <= 1'b0;
			for (int s = 0; s < pfa_pkg::MAX_PROCESSES; s++) begin
				pvalid_q[s] <= 1'b0;
			end
		end else begin
			// configuration writes
			if (cfg_we) begin
				if (cfg_index == pfa_pkg::CFG_PAGE_SIZE) begin
					page_size_q <= cfg_wdata;
				end else begin
					frame_count_q <= cfg_wdata[CW-1:0];
				end
			end

			// result taken; a new one from S_DONE replaces it below
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end

			// divider runs whenever armed
			if (div_cnt_q != 5'd19) begin
				rem_q     <= ge ? 13'(rsh - {1'b0, ps_eff}) : rsh[12:0];
				quo_q     <= {quo_q[17:0], ge};
				div_d_q   <= {div_d_q[17:0], 1'b0};
				div_cnt_q <= div_cnt_q + 5'd1;
			end

			case (state_q)
				S_CLEAR: begin
					// mark every frame free, one per cycle
					scan_q <= scan_q + CW'(1);
					if (scan_q == NFRAMES - CW'(1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						cmd_q     <= cmd;
						pid_q     <= pid;
						page_q    <= page_index;
						div_d_q   <= size_bytes;
						quo_q     <= '0;
						rem_q     <= '0;
						div_cnt_q <= '0;
						scan_q    <= '0;
						rd_v_s1   <= 1'b0;
						free_q    <= '0;
						res_frame_q <= '0;
						state_q   <= S_COUNT;
					end
				end
				S_COUNT: begin
					if (scan_q != NFRAMES) begin
						rd_v_s1    <= 1'b1;
						rd_addr_s1 <= scan_q[FW-1:0];
						scan_q     <= scan_q + CW'(1);
					end else begin
						rd_v_s1 <= 1'b0;
					end
					if (resp_free) begin
						free_q <= free_q + CW'(1);
					end
					if (scan_q == NFRAMES && !rd_v_s1 && div_cnt_q == 5'd19) begin
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					res_status_q <= pfa_pkg::ST_OK;
					slot_q       <= hit_slot;
					have_q       <= have_c;
					want_q       <= want_c;
					scan_q       <= '0;
					rd_v_s1      <= 1'b0;
					state_q      <= S_DONE;
					if (cmd_q == pfa_pkg::CMD_CREATE) begin
						if (!hit) begin
							if (has_free) begin
								pvalid_q[free_slot]  <= 1'b1;
								pid_tab_q[free_slot] <= pid_q;
								pcnt_q[free_slot]    <= '0;
							end else begin
								res_status_q <= pfa_pkg::ST_FULL;
							end
						end
					end else if (!hit) begin
						res_status_q <= pfa_pkg::ST_UNKNOWN;
					end else begin
						case (cmd_q)
							pfa_pkg::CMD_REMOVE: begin
								pvalid_q[hit_slot] <= 1'b0;
							end
							pfa_pkg::CMD_RESIZE: begin
								if (too_big) begin
									res_status_q <= pfa_pkg::ST_OOM;
								end else if (want_c < have_c) begin
									state_q <= S_SH_RD;
								end else if (want_c > have_c) begin
									if (free_q < want_c - have_c) begin
										res_status_q <= pfa_pkg::ST_OOM;
									end else begin
										state_q <= S_GROW;
									end
								end
							end
							default: begin
								// translate
								if ({1'b0, page_q} < have_c) begin
									state_q <= S_TR_WAIT;
								end else begin
									res_status_q <= pfa_pkg::ST_RANGE;
								end
							end
						endcase
					end
				end
				S_GROW: begin
					if (scan_q != NFRAMES) begin
						rd_v_s1    <= 1'b1;
						rd_addr_s1 <= scan_q[FW-1:0];
						scan_q     <= scan_q + CW'(1);
					end else begin
						rd_v_s1 <= 1'b0;
					end
					if (have_q == want_q) begin
						pcnt_q[slot_q] <= want_q;
						state_q        <= S_DONE;
					end else if (resp_free) begin
						have_q <= have_q + CW'(1);
						free_q <= free_q - CW'(1);
					end
				end
				S_SH_RD: begin
					if (have_q == want_q) begin
						pcnt_q[slot_q] <= want_q;
						state_q        <= S_DONE;
					end else begin
						have_q  <= have_q - CW'(1);
						state_q <= S_SH_WR;
					end
				end
				S_SH_WR: begin
					if ({1'b0, pt_rdata} < frames_act) begin
						free_q <= free_q + CW'(1);
					end
					state_q <= S_SH_RD;
				end
				S_TR_WAIT: begin
					res_frame_q <= pt_rdata;
					state_q     <= S_DONE;
				end
				S_DONE: begin
					rd_v_s1 <= 1'b0;
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						status_q    <= res_status_q;
						frame_q     <= res_frame_q;
						free_out_q  <= free_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall    = (state_q != S_IDLE);
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign frame       = frame_q;
	assign free_frames = free_out_q;

endmodule
